// File: src/csr_sparse_matvec_sparse_vector_macros.svh
// ----------------------------------------------------------------------------
// csr_sparse_matvec_sparse_vector_macros
// Assertion helpers used by the top RTL file of the block.
// ----------------------------------------------------------------------------
`ifndef CSR_SPARSE_MATVEC_SPARSE_VECTOR_MACROS_SVH
`define CSR_SPARSE_MATVEC_SPARSE_VECTOR_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define CSRSMV_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define CSRSMV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: src/csrsmv_pkg.sv
// ----------------------------------------------------------------------------
// csrsmv_pkg
// Types and constants of the sparse matrix / sparse vector product block.
// ----------------------------------------------------------------------------
`default_nettype none

package csrsmv_pkg;

    localparam int MAX_VEC_ENTRIES = 1024;
    localparam int ADDR_W = (MAX_VEC_ENTRIES > 1) ? $clog2(MAX_VEC_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_VEC_ENTRIES + 1);

    localparam int IDX_W = 31;
    localparam int COEF_W = 32;
    localparam int ROW_W = 31;
    localparam int SUM_W = 64;
    localparam int KIND_W = 2;

    localparam int IN_TDATA_W = 96;
    localparam int OUT_TDATA_W = 96;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD  = 2'd0,
        KIND_MAT   = 2'd1,
        KIND_EMPTY = 2'd2,
        KIND_CLEAR = 2'd3
    } t_kind;

    typedef struct packed {
        logic [IDX_W-1:0]         index;
        logic signed [COEF_W-1:0] coef;
    } t_vec_entry;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        t_vec_entry        data;
    } t_mem_wr;

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic clr;
    } t_mac_ctrl;

endpackage

`default_nettype wire

// File: src/csrsmv_vec_mem.sv
// ----------------------------------------------------------------------------
// csrsmv_vec_mem
// Sorted vector store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module csrsmv_vec_mem (
    input  wire logic                         i_clk,
    input  wire csrsmv_pkg::t_mem_wr          i_wr,
    input  wire logic [csrsmv_pkg::ADDR_W-1:0] i_rd_addr,
    output csrsmv_pkg::t_vec_entry            o_rd_data
);

    csrsmv_pkg::t_vec_entry r_mem [csrsmv_pkg::MAX_VEC_ENTRIES];
    csrsmv_pkg::t_vec_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: src/csrsmv_mac.sv
// ----------------------------------------------------------------------------
// csrsmv_mac
// Q16.16 x Q16.16 multiply into a saturating Q32.32 row accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module csrsmv_mac (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire csrsmv_pkg::t_mac_ctrl               i_ctrl,
    input  wire logic signed [csrsmv_pkg::COEF_W-1:0] i_a,
    input  wire logic signed [csrsmv_pkg::COEF_W-1:0] i_b,
    output logic signed [csrsmv_pkg::SUM_W-1:0]      o_acc
);

    localparam int SW = csrsmv_pkg::SUM_W;

    logic signed [SW-1:0] r_prod;
    logic signed [SW-1:0] r_acc;
    logic signed [SW-1:0] n_acc;
    logic signed [SW:0]   sum_ext;

    always_comb begin
        sum_ext = {r_acc[SW-1], r_acc} + {r_prod[SW-1], r_prod};
        if (sum_ext[SW] != sum_ext[SW-1]) begin
            n_acc = sum_ext[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end else begin
            n_acc = sum_ext[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= SW'(i_a) * SW'(i_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctrl.clr) begin
            r_acc <= '0;
        end else if (i_ctrl.acc_en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

// File: src/csr_sparse_matvec_sparse_vector.sv
// ----------------------------------------------------------------------------
// csr_sparse_matvec_sparse_vector
// Sparse matrix times sparse vector: sorted vector store, binary search per
// matrix entry, saturating Q32.32 row sums.
//
// Channel   Dir  Signals          Contents
// s_axis    in   tvalid/tready    tuser: kind; tlast: row_end
//                                 tdata: index, coef, row_number
// m_axis    out  tvalid/tready    tdata: out_row, row_sum, load_error
//
// Load and clear requests leave the block idle, ready for the next request.
// A matrix entry probes the store once per binary-search step (at most 11
// probes for 1024 entries), then on a hit accumulates in S_ACC, then S_FIN.
// Empty-row requests go straight to S_FIN. The probe loop runs over the
// store's single read port; no new request is taken until back in S_IDLE.
// Reset clears count, error flag, accumulator and output valid flag; the
// store needs no clearing. A stalled m_axis holds only requests that emit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "csr_sparse_matvec_sparse_vector_macros.svh"

module csr_sparse_matvec_sparse_vector (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_s_axis_tvalid,
    output logic                                      o_s_axis_tready,
    // [30:0] index, [62:31] coef, [93:63] row_number, [95:94] zero
    input  wire logic [csrsmv_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // [1:0] kind
    input  wire logic [csrsmv_pkg::KIND_W-1:0]        i_s_axis_tuser,
    input  wire logic                                 i_s_axis_tlast,
    output logic                                      o_m_axis_tvalid,
    input  wire logic                                 i_m_axis_tready,
    // [30:0] out_row, [94:31] row_sum, [95] load_error
    output logic [csrsmv_pkg::OUT_TDATA_W-1:0]        o_m_axis_tdata
);

    localparam int AW = csrsmv_pkg::ADDR_W;
    localparam int CW = csrsmv_pkg::CNT_W;
    localparam int IW = csrsmv_pkg::IDX_W;
    localparam int KW = csrsmv_pkg::COEF_W;
    localparam int RW = csrsmv_pkg::ROW_W;
    localparam int SW = csrsmv_pkg::SUM_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(csrsmv_pkg::MAX_VEC_ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_ACC    = 4'b0100,
        S_FIN    = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [IW-1:0]        in_index;
    logic signed [KW-1:0] in_coef;
    logic [RW-1:0]        in_row;
    csrsmv_pkg::t_kind    in_kind;
    logic                 in_acc;

    logic [CW-1:0]        r_count;
    logic                 r_err;
    logic [IW-1:0]        r_last_index;
    logic [IW-1:0]        r_key;
    logic signed [KW-1:0] r_coef;
    logic [RW-1:0]        r_row;
    logic                 r_row_end;
    logic                 r_zero;
    logic [CW-1:0]        r_lo;
    logic [CW-1:0]        r_hi;
    logic [AW-1:0]        r_mid;

    logic                 r_m_tvalid;
    logic [csrsmv_pkg::OUT_TDATA_W-1:0] r_m_tdata;

    csrsmv_pkg::t_mem_wr    mem_wr;
    csrsmv_pkg::t_vec_entry rd_data;
    csrsmv_pkg::t_mac_ctrl  mac_ctrl;
    logic signed [SW-1:0]   acc;

    logic [CW-1:0] lo_sel, hi_sel, n_lo, n_hi;
    logic [CW:0]   mid_sum;
    logic [AW-1:0] rd_addr;
    logic          load_bad;
    logic          hit, probe_lt, out_free, emit_go;

    assign in_index = i_s_axis_tdata[IW-1:0];
    assign in_coef  = i_s_axis_tdata[IW+KW-1:IW];
    assign in_row   = i_s_axis_tdata[IW+KW+RW-1:IW+KW];
    assign in_kind  = csrsmv_pkg::t_kind'(i_s_axis_tuser);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;

    assign load_bad = (r_count == MAX_CNT) ||
                      ((r_count != '0) && (in_index <= r_last_index));

    // search step
    assign hit      = (rd_data.index == r_key);
    assign probe_lt = (rd_data.index < r_key);
    assign n_lo     = probe_lt ? ({1'b0, r_mid} + CW'(1)) : r_lo;
    assign n_hi     = probe_lt ? r_hi : {1'b0, r_mid};

    always_comb begin
        if (r_state == S_IDLE) begin
            lo_sel = '0;
            hi_sel = r_count;
        end else begin
            lo_sel = n_lo;
            hi_sel = n_hi;
        end
        mid_sum = ({1'b0, lo_sel} + {1'b0, hi_sel}) >> 1;
        rd_addr = mid_sum[AW-1:0];
    end

    assign out_free = !r_m_tvalid || i_m_axis_tready;
    assign emit_go  = (r_state == S_FIN) && r_row_end && out_free;

    always_comb begin
        mem_wr.en   = in_acc && (in_kind == csrsmv_pkg::KIND_LOAD) && !load_bad;
        mem_wr.addr = r_count[AW-1:0];
        mem_wr.data.index = in_index;
        mem_wr.data.coef  = in_coef;
    end

    always_comb begin
        mac_ctrl.mul_en = (r_state == S_SEARCH) && hit;
        mac_ctrl.acc_en = (r_state == S_ACC);
        mac_ctrl.clr    = emit_go && !r_zero;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (in_kind)
                        csrsmv_pkg::KIND_MAT:
                            n_state = (r_count == '0) ? S_FIN : S_SEARCH;
                        csrsmv_pkg::KIND_EMPTY:
                            n_state = S_FIN;
                        default:
                            n_state = S_IDLE;
                    endcase
                end
            end
            S_SEARCH: begin
                if (hit) begin
                    n_state = S_ACC;
                end else if (n_lo >= n_hi) begin
                    n_state = S_FIN;
                end
            end
            S_ACC: n_state = S_FIN;
            S_FIN: begin
                if (!r_row_end || out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_err      <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc && (in_kind == csrsmv_pkg::KIND_LOAD)) begin
                if (load_bad) begin
                    r_err <= 1'b1;
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end else if (in_acc && (in_kind == csrsmv_pkg::KIND_CLEAR)) begin
                r_count <= '0;
                r_err   <= 1'b0;
            end
            if (emit_go) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_wr.en) begin
            r_last_index <= in_index;
        end
        if (in_acc) begin
            r_key     <= in_index;
            r_coef    <= in_coef;
            r_row     <= in_row;
            r_row_end <= (in_kind == csrsmv_pkg::KIND_EMPTY) || i_s_axis_tlast;
            r_zero    <= (in_kind == csrsmv_pkg::KIND_EMPTY);
        end
        if ((r_state == S_IDLE) || (r_state == S_SEARCH)) begin
            r_lo  <= lo_sel;
            r_hi  <= hi_sel;
            r_mid <= rd_addr;
        end
        if (emit_go) begin
            r_m_tdata <= {r_err, (r_zero ? {SW{1'b0}} : acc), r_row};
        end
    end

    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = r_m_tdata;

    csrsmv_vec_mem u_vec_mem (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    csrsmv_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (mac_ctrl),
        .i_a     (r_coef),
        .i_b     (rd_data.coef),
        .o_acc   (acc)
    );

    `CSRSMV_ASSERT_SAME(a_search_range, r_state == S_SEARCH, r_lo < r_hi, "search range empty")
    `CSRSMV_ASSERT_SAME(a_count_cap, 1'b1, r_count <= MAX_CNT, "vector count over capacity")
    `CSRSMV_ASSERT_NEXT(a_empty_store, in_acc && in_kind == csrsmv_pkg::KIND_MAT && r_count == '0, r_state == S_FIN, "empty store must miss at once")
    `CSRSMV_ASSERT_NEXT(a_emit_hold, r_state == S_FIN && r_row_end && r_m_tvalid && !i_m_axis_tready, r_state == S_FIN, "row result lost on stall")

endmodule

`default_nettype wire

// File: dv/csrsmv_row_sum_checker.sv
// ----------------------------------------------------------------------------
// csrsmv_row_sum_checker
// Watches both stream channels of the sparse matrix / sparse vector block.
// Every accepted request is run through a local model of the sorted vector
// store and the saturating Q32.32 row accumulator; each emitted row result is
// compared field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module csrsmv_row_sum_checker
    import csrsmv_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    input  wire logic                   i_s_tready,
    // [30:0] index, [62:31] coef, [93:63] row_number, [95:94] zero
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    // [1:0] kind
    input  wire logic [KIND_W-1:0]      i_s_tuser,
    input  wire logic                   i_s_tlast,
    input  wire logic                   i_m_tvalid,
    input  wire logic                   i_m_tready,
    // [30:0] out_row, [94:31] row_sum, [95] load_error
    input  wire logic [OUT_TDATA_W-1:0] i_m_tdata,
    output int                          o_mismatches,
    output int                          o_outstanding
);

    typedef struct {
        logic [ROW_W-1:0]        row;
        logic signed [SUM_W-1:0] sum;
        logic                    load_err;
    } row_result_t;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    logic [IDX_W-1:0]         vec_keys [MAX_VEC_ENTRIES];
    logic signed [COEF_W-1:0] vec_vals [MAX_VEC_ENTRIES];
    int                       vec_fill;
    logic signed [SUM_W-1:0]  row_acc;
    logic                     load_err;
    row_result_t              row_results_q[$];
    int                       mismatches;
    int                       n_rows_checked;

    assign o_mismatches = mismatches;

    task automatic report_mismatch(string msg);
        $display("%s", msg);
        mismatches++;
    endtask

    function automatic int find_key(logic [IDX_W-1:0] key);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = vec_fill - 1;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (vec_keys[mid] == key)
                return mid;
            if (vec_keys[mid] < key)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return -1;
    endfunction

    function automatic logic signed [SUM_W-1:0] add_sat(logic signed [SUM_W-1:0] a,
                                                       logic signed [SUM_W-1:0] b);
        logic signed [SUM_W:0] s;
        s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
        if (s[SUM_W] != s[SUM_W-1])
            return s[SUM_W] ? SUM_MIN : SUM_MAX;
        return s[SUM_W-1:0];
    endfunction

    task automatic apply_request(t_kind kind, logic [IDX_W-1:0] idx,
                                 logic signed [COEF_W-1:0] coef,
                                 logic [ROW_W-1:0] row, logic row_end);
        int                      slot;
        logic signed [SUM_W-1:0] a;
        logic signed [SUM_W-1:0] b;
        row_result_t             res;
        case (kind)
            KIND_LOAD: begin
                if (vec_fill >= MAX_VEC_ENTRIES ||
                    (vec_fill > 0 && idx <= vec_keys[vec_fill-1])) begin
                    load_err = 1'b1;
                end else begin
                    vec_keys[vec_fill] = idx;
                    vec_vals[vec_fill] = coef;
                    vec_fill++;
                end
            end
            KIND_MAT: begin
                slot = find_key(idx);
                if (slot >= 0) begin
                    a = SUM_W'(coef);
                    b = SUM_W'(vec_vals[slot]);
                    row_acc = add_sat(row_acc, a * b);
                end
                if (row_end) begin
                    res.row = row;
                    res.sum = row_acc;
                    res.load_err = load_err;
                    row_results_q.push_back(res);
                    row_acc = '0;
                end
            end
            KIND_EMPTY: begin
                res.row = row;
                res.sum = '0;
                res.load_err = load_err;
                row_results_q.push_back(res);
            end
            default: begin
                vec_fill = 0;
                load_err = 1'b0;
            end
        endcase
    endtask

    task automatic check_result(logic [OUT_TDATA_W-1:0] tdata);
        row_result_t want;
        if (row_results_q.size() == 0) begin
            report_mismatch($sformatf("unexpected row result, tdata %h", tdata));
            return;
        end
        want = row_results_q.pop_front();
        if (tdata[30:0] !== want.row)
            report_mismatch($sformatf("result %0d out_row: got %h, want %h",
                                      n_rows_checked, tdata[30:0], want.row));
        if (tdata[94:31] !== want.sum)
            report_mismatch($sformatf("result %0d row_sum: got %h, want %h",
                                      n_rows_checked, tdata[94:31], want.sum));
        if (tdata[95] !== want.load_err)
            report_mismatch($sformatf("result %0d load_error: got %b, want %b",
                                      n_rows_checked, tdata[95], want.load_err));
        n_rows_checked++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            row_results_q.delete();
            vec_fill = 0;
            row_acc = '0;
            load_err = 1'b0;
        end else begin
            if (i_m_tvalid && i_m_tready)
                check_result(i_m_tdata);
            if (i_s_tvalid && i_s_tready)
                apply_request(t_kind'(i_s_tuser), i_s_tdata[30:0], i_s_tdata[62:31],
                              i_s_tdata[93:63], i_s_tlast);
        end
        o_outstanding <= row_results_q.size();
    end

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Regression for the sparse matrix / sparse vector block: a directed run over
// loads, errors, saturation and store clears, then random vector loads and
// compressed-row matrix traffic under three idling profiles, a long output
// hold-off and a full-store load. Checking is done by csrsmv_row_sum_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import csrsmv_pkg::*;

    localparam int TAIL_CYCLES = 32;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_REQS = 240;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [KIND_W-1:0]      s_tuser;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    int                     mismatches;
    int                     outstanding;

    int                     src_idle_pct;
    int                     snk_idle_pct;
    bit                     hold_req;
    bit                     hold_done;
    int                     reqs_sent;
    logic [IDX_W-1:0]       loaded_q[$];

    csr_sparse_matvec_sparse_vector dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    csrsmv_row_sum_checker u_row_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_s_tlast     (s_tlast),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                m_tready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    function automatic logic [IDX_W-1:0] rand_idx();
        return IDX_W'($urandom());
    endfunction

    function automatic logic [ROW_W-1:0] rand_row();
        return ROW_W'($urandom());
    endfunction

    function automatic logic rand_flag();
        return 1'($urandom_range(1));
    endfunction

    task automatic send_req(t_kind kind, logic [IDX_W-1:0] idx, logic [COEF_W-1:0] coef,
                            logic [ROW_W-1:0] row, logic row_end);
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < src_idle_pct) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, row, coef, idx};
        s_tuser  <= kind;
        s_tlast  <= row_end;
        do @(posedge i_clk); while (!s_tready);
        reqs_sent++;
        // keep a copy of the stored keys to aim columns at
        if (kind == KIND_CLEAR)
            loaded_q.delete();
        else if (kind == KIND_LOAD && loaded_q.size() < MAX_VEC_ENTRIES &&
                 (loaded_q.size() == 0 || idx > loaded_q[$]))
            loaded_q.push_back(idx);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    function automatic logic [COEF_W-1:0] pick_coef();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] pick_col();
        if (loaded_q.size() > 0 && $urandom_range(9) < 7)
            return loaded_q[$urandom_range(loaded_q.size() - 1)];
        return rand_idx();
    endfunction

    // sorted load with occasional duplicate or out-of-order requests
    task automatic load_vector(int n);
        logic [IDX_W-1:0] keys[$];
        logic [IDX_W-1:0] last;
        keys = {};
        for (int i = 0; i < n; i++)
            keys.push_back(rand_idx());
        keys.sort();
        send_req(KIND_CLEAR, rand_idx(), $urandom(), rand_row(), rand_flag());
        for (int i = 0; i < keys.size(); i++) begin
            if (i > 0 && keys[i] == keys[i-1])
                continue;
            send_req(KIND_LOAD, keys[i], pick_coef(), rand_row(), rand_flag());
            if ($urandom_range(19) == 0 && loaded_q.size() > 0) begin
                last = loaded_q[$];
                if (last >= 4)
                    last = last - IDX_W'($urandom_range(3));
                send_req(KIND_LOAD, last, pick_coef(), rand_row(), rand_flag());
            end
        end
    endtask

    task automatic send_rows(int n_rows);
        logic [ROW_W-1:0] row;
        int               n;
        row = rand_row();
        repeat (n_rows) begin
            n = $urandom_range(6);
            if (n == 0) begin
                send_req(KIND_EMPTY, rand_idx(), $urandom(), row, rand_flag());
            end else begin
                for (int j = 0; j < n; j++)
                    send_req(KIND_MAT, pick_col(), pick_coef(), row, j == n - 1);
            end
            row++;
        end
    endtask

    task automatic send_noise();
        send_req(t_kind'($urandom_range(3)), rand_idx(), $urandom(), rand_row(),
                 rand_flag());
    endtask

    initial begin
        int               stop_at;
        int               pick;
        logic [IDX_W-1:0] key;
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        s_tlast  <= 1'b0;
        hold_req = 1'b0;
        reqs_sent = 0;
        src_idle_pct = 9;
        snk_idle_pct = 55;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty store, load errors, saturation both ways, clear
        send_req(KIND_MAT,   31'd5,          32'h0001_0000, 31'd0,          1'b1);
        send_req(KIND_LOAD,  31'd0,          32'h8000_0000, 31'h7FFF_FFFF,  1'b1);
        send_req(KIND_LOAD,  31'd5,          32'h7FFF_FFFF, 31'd0,          1'b0);
        send_req(KIND_LOAD,  31'd5,          32'h0000_0001, 31'd0,          1'b0);
        send_req(KIND_LOAD,  31'd3,          32'h0000_0001, 31'd0,          1'b0);
        send_req(KIND_LOAD,  31'h7FFF_FFFF,  32'h0001_0000, 31'd0,          1'b0);
        send_req(KIND_EMPTY, 31'h7FFF_FFFF,  32'hFFFF_FFFF, 31'h7FFF_FFFF,  1'b1);
        repeat (3)
            send_req(KIND_MAT, 31'd0,        32'h8000_0000, 31'd1,          1'b0);
        send_req(KIND_EMPTY, 31'd0,          32'd0,         31'd7,          1'b0);
        send_req(KIND_MAT,   31'd0,          32'h7FFF_FFFF, 31'd1,          1'b1);
        repeat (3)
            send_req(KIND_MAT, 31'd0,        32'h7FFF_FFFF, 31'd2,          1'b0);
        send_req(KIND_MAT,   31'h7FFF_FFFF,  32'hFFFF_FFFF, 31'd2,          1'b1);
        send_req(KIND_MAT,   31'd4,          32'h7FFF_FFFF, 31'd3,          1'b1);
        send_req(KIND_MAT,   31'h7FFF_FFFF,  32'h8000_0000, 31'd4,          1'b1);
        send_req(KIND_CLEAR, 31'h7FFF_FFFF,  32'hFFFF_FFFF, 31'h7FFF_FFFF,  1'b1);
        send_req(KIND_MAT,   31'd0,          32'h8000_0000, 31'd5,          1'b1);
        send_req(KIND_LOAD,  31'd0,          32'hFFFF_FFFF, 31'd0,          1'b0);
        send_req(KIND_MAT,   31'd0,          32'h7FFF_FFFF, 31'h7FFF_FFFF,  1'b1);
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 55 : 0;
            snk_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 9 : 0;
            if (phase == 2) begin
                // long output hold-off: input must back up behind it
                hold_req = 1'b1;
                repeat (40)
                    send_req(KIND_EMPTY, rand_idx(), $urandom(), rand_row(),
                             rand_flag());
                wait_drained();
                // full store, then loads beyond capacity
                load_vector(MAX_VEC_ENTRIES);
                while (loaded_q.size() < MAX_VEC_ENTRIES && loaded_q[$] != '1)
                    send_req(KIND_LOAD, loaded_q[$] + 1'b1, pick_coef(), rand_row(), 1'b0);
                for (int i = 0; i < 3; i++) begin
                    key = (loaded_q[$] == '1) ? loaded_q[$] : loaded_q[$] + 1'b1;
                    send_req(KIND_LOAD, key, pick_coef(), rand_row(), 1'b0);
                end
                send_rows(40);
            end
            stop_at = reqs_sent + PHASE_REQS;
            while (reqs_sent < stop_at) begin
                pick = $urandom_range(99);
                if (pick < 12)
                    load_vector($urandom_range(1, 40));
                else if (pick < 88)
                    send_rows($urandom_range(1, 6));
                else
                    send_noise();
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
